// ===== hw/rtl/gravity_pair_force_unit_defines.svh =====
// assertion macros for the gravity pair force unit
// used by the top level only, expects clk and arst_n in scope
`ifndef GRAVITY_PAIR_FORCE_UNIT_DEFINES_SVH
`define GRAVITY_PAIR_FORCE_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define GPF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gravity pair force check failed");

// next-cycle implication, held off during reset
`define GPF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gravity pair force check failed");

`endif

// ===== hw/rtl/gpf_pkg.sv =====
// shared types and constants of the gravity pair force unit
// no dependencies
package gpf_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int DIST2_W = 66;
	localparam int ROOT_W  = 34;
	localparam int SQ_W    = 68;
	localparam int K_W     = 96;
	localparam int NUM_W   = 128;
	localparam int DEN_W   = 102;
	localparam int Q_W     = 47;
	localparam int FORCE_W = 48;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE   = 2'd1;

	localparam logic [Q_W-1:0] FORCE_MAX = {Q_W{1'b1}};

	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
		logic [COORD_W-1:0]        first_mass;
		logic [COORD_W-1:0]        second_mass;
	} in_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_x;
		logic signed [FORCE_W-1:0] force_y;
		logic                      applied;
	} out_t;

	// data riding along the square root chain
	typedef struct packed {
		logic [K_W-1:0]    k;
		logic [DIFF_W-1:0] ax;
		logic [DIFF_W-1:0] ay;
		logic              neg_x;
		logic              neg_y;
	} sqrt_side_t;

	// flags riding along the divider chain
	typedef struct packed {
		logic sat_x;
		logic sat_y;
		logic neg_x;
		logic neg_y;
		logic applied;
	} div_side_t;

endpackage

// ===== hw/rtl/gpf_sqrt_cell.sv =====
// one bit of the pipelined integer square root
// depends on gpf_pkg
module gpf_sqrt_cell import gpf_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  logic [DIST2_W-1:0] v_in,
	input  logic [ROOT_W-1:0]  s_in,
	input  logic [SQ_W-1:0]    sq_in,
	input  sqrt_side_t         side_in,
	output logic               valid_out,
	output logic [DIST2_W-1:0] v_out,
	output logic [ROOT_W-1:0]  s_out,
	output logic [SQ_W-1:0]    sq_out,
	output sqrt_side_t         side_out
);

	localparam int W = SQ_W + 1;

	logic [W-1:0] trial;
	logic         take;

	// (s + 2^b)^2 = s^2 + s*2^(b+1) + 2^(2b)
	assign trial = {1'b0, sq_in} + ({{(W-ROOT_W){1'b0}}, s_in} << (BIT + 1))
		+ ({{(W-1){1'b0}}, 1'b1} << (2 * BIT));
	assign take = {{(W-DIST2_W){1'b0}}, v_in} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_out    <= v_in;
			side_out <= side_in;
			s_out    <= take ? (s_in | (ROOT_W'(1) << BIT)) : s_in;
			sq_out   <= take ? trial[SQ_W-1:0] : sq_in;
		end
	end

endmodule

// ===== hw/rtl/gpf_div_cell.sv =====
// one quotient bit of the two-lane restoring divider
// depends on gpf_pkg
module gpf_div_cell import gpf_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_in,
	input  logic [NUM_W-1:0] rem_x_in,
	input  logic [NUM_W-1:0] rem_y_in,
	input  logic [Q_W-1:0]   q_x_in,
	input  logic [Q_W-1:0]   q_y_in,
	input  logic [DEN_W-1:0] den_in,
	input  div_side_t        side_in,
	output logic             valid_out,
	output logic [NUM_W-1:0] rem_x_out,
	output logic [NUM_W-1:0] rem_y_out,
	output logic [Q_W-1:0]   q_x_out,
	output logic [Q_W-1:0]   q_y_out,
	output logic [DEN_W-1:0] den_out,
	output div_side_t        side_out
);

	localparam int W = DEN_W + Q_W + 1;

	logic [W-1:0] dsh;
	logic         ge_x;
	logic         ge_y;

	assign dsh  = {{(W-DEN_W){1'b0}}, den_in} << BIT;
	assign ge_x = {{(W-NUM_W){1'b0}}, rem_x_in} >= dsh;
	assign ge_y = {{(W-NUM_W){1'b0}}, rem_y_in} >= dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_out   <= den_in;
			side_out  <= side_in;
			rem_x_out <= ge_x ? rem_x_in - dsh[NUM_W-1:0] : rem_x_in;
			rem_y_out <= ge_y ? rem_y_in - dsh[NUM_W-1:0] : rem_y_in;
			q_x_out   <= ge_x ? (q_x_in | (Q_W'(1) << BIT)) : q_x_in;
			q_y_out   <= ge_y ? (q_y_in | (Q_W'(1) << BIT)) : q_y_in;
		end
	end

endmodule

// ===== hw/rtl/gravity_pair_force_unit.sv =====
// gravity pair force unit: pipelined, one request per cycle unless stalled,
// sustained through a chain of 34 root cells and 47 divider cells
// the whole pipe advances together; a result held under stall holds the pipe
// reset clears all valid bits and sets G and the close distance to 1.0
// depends on gpf_pkg, gpf_sqrt_cell, gpf_div_cell, gravity_pair_force_unit_defines.svh
`include "gravity_pair_force_unit_defines.svh"
module gravity_pair_force_unit import gpf_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data
);

	localparam int NS = ROOT_W;
	localparam int ND = Q_W;

	logic [31:0] gravity_q;
	logic [31:0] close_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= 32'd1 << FRAC_BITS;
			close_q   <= 32'd1 << FRAC_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRAVITY: gravity_q <= cfg_data;
				CFG_CLOSE:   close_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic out_valid_q;
	out_t out_data_q;

	assign en        = !out_valid_q || !out_stall;
	assign in_stall  = !en;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// front: differences, magnitudes, squares, G*m1*m2
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [DIFF_W-1:0] rx_s1, ry_s1;
	logic [31:0]       m1_s1, m2_s1, m2_s2, m2_s3;
	logic [DIFF_W-1:0] ax_s2, ay_s2, ax_s3, ay_s3, ax_s4, ay_s4;
	logic              nx_s2, ny_s2, nx_s3, ny_s3, nx_s4, ny_s4;
	logic [31:0]       m1_s2;
	logic [DIST2_W-1:0] ax2_s3, ay2_s3, d2_s4, d2_s5;
	logic [63:0]       gm_s3, kl_s4, kh_s4;
	sqrt_side_t        side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= {in_data.second_x[31], in_data.second_x}
				- {in_data.first_x[31], in_data.first_x};
			ry_s1 <= {in_data.second_y[31], in_data.second_y}
				- {in_data.first_y[31], in_data.first_y};
			m1_s1 <= in_data.first_mass;
			m2_s1 <= in_data.second_mass;

			nx_s2 <= rx_s1[DIFF_W-1];
			ny_s2 <= ry_s1[DIFF_W-1];
			ax_s2 <= rx_s1[DIFF_W-1] ? ~rx_s1 + DIFF_W'(1) : rx_s1;
			ay_s2 <= ry_s1[DIFF_W-1] ? ~ry_s1 + DIFF_W'(1) : ry_s1;
			m1_s2 <= m1_s1;
			m2_s2 <= m2_s1;

			ax2_s3 <= {33'b0, ax_s2} * {33'b0, ax_s2};
			ay2_s3 <= {33'b0, ay_s2} * {33'b0, ay_s2};
			gm_s3  <= {32'b0, gravity_q} * {32'b0, m1_s2};
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
			m2_s3  <= m2_s2;

			d2_s4 <= ax2_s3 + ay2_s3;
			kl_s4 <= {32'b0, gm_s3[31:0]} * {32'b0, m2_s3};
			kh_s4 <= {32'b0, gm_s3[63:32]} * {32'b0, m2_s3};
			ax_s4 <= ax_s3;
			ay_s4 <= ay_s3;
			nx_s4 <= nx_s3;
			ny_s4 <= ny_s3;

			d2_s5         <= d2_s4;
			side_s5.k     <= {32'b0, kl_s4} + {kh_s4, 32'b0};
			side_s5.ax    <= ax_s4;
			side_s5.ay    <= ay_s4;
			side_s5.neg_x <= nx_s4;
			side_s5.neg_y <= ny_s4;
		end
	end

	// square root chain, most significant root bit first
	logic               sv   [NS+1];
	logic [DIST2_W-1:0] sd2  [NS+1];
	logic [ROOT_W-1:0]  ss   [NS+1];
	logic [SQ_W-1:0]    ssq  [NS+1];
	sqrt_side_t         sside[NS+1];

	assign sv[0]    = v_s5;
	assign sd2[0]   = d2_s5;
	assign ss[0]    = '0;
	assign ssq[0]   = '0;
	assign sside[0] = side_s5;

	for (genvar i = 0; i < NS; i++) begin : g_sqrt
		gpf_sqrt_cell #(.BIT(NS - 1 - i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (sv[i]),
			.v_in     (sd2[i]),
			.s_in     (ss[i]),
			.sq_in    (ssq[i]),
			.side_in  (sside[i]),
			.valid_out(sv[i+1]),
			.v_out    (sd2[i+1]),
			.s_out    (ss[i+1]),
			.sq_out   (ssq[i+1]),
			.side_out (sside[i+1])
		);
	end

	// numerator and d^3
	sqrt_side_t  sq_end;
	logic        v_t1, v_t2, v_t3, v_t4;
	logic        ap_t1, ap_t2, ap_t3;
	logic        nx_t1, ny_t1, nx_t2, ny_t2, nx_t3, ny_t3;
	logic [ROOT_W-1:0] d_t1;
	logic [SQ_W-1:0]   dd_t1;
	logic [64:0]  nx0_t1, nx1_t1, nx2_t1, ny0_t1, ny1_t1, ny2_t1;
	logic [NUM_W-1:0] numx_t2, numy_t2, numx_t3, numy_t3, numx_t4, numy_t4;
	logic [SQ_W-1:0]  dp0_t2, dp1_t2;
	logic [DEN_W-1:0] den_t3, den_t4;
	div_side_t        side_t4;

	assign sq_end = sside[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1 <= 1'b0;
			v_t2 <= 1'b0;
			v_t3 <= 1'b0;
			v_t4 <= 1'b0;
		end else if (en) begin
			v_t1 <= sv[NS];
			v_t2 <= v_t1;
			v_t3 <= v_t2;
			v_t4 <= v_t3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_t1   <= ss[NS];
			ap_t1  <= ss[NS] > {2'b0, close_q};
			dd_t1  <= {34'b0, ss[NS]} * {34'b0, ss[NS]};
			nx0_t1 <= {33'b0, sq_end.k[31:0]}  * {32'b0, sq_end.ax};
			nx1_t1 <= {33'b0, sq_end.k[63:32]} * {32'b0, sq_end.ax};
			nx2_t1 <= {33'b0, sq_end.k[95:64]} * {32'b0, sq_end.ax};
			ny0_t1 <= {33'b0, sq_end.k[31:0]}  * {32'b0, sq_end.ay};
			ny1_t1 <= {33'b0, sq_end.k[63:32]} * {32'b0, sq_end.ay};
			ny2_t1 <= {33'b0, sq_end.k[95:64]} * {32'b0, sq_end.ay};
			nx_t1  <= sq_end.neg_x;
			ny_t1  <= sq_end.neg_y;

			// product stays below 2^128, top bits of the partials drop out
			numx_t2 <= NUM_W'(nx0_t1) + (NUM_W'(nx1_t1) << 32) + (NUM_W'(nx2_t1) << 64);
			numy_t2 <= NUM_W'(ny0_t1) + (NUM_W'(ny1_t1) << 32) + (NUM_W'(ny2_t1) << 64);
			dp0_t2  <= {34'b0, dd_t1[33:0]}  * {34'b0, d_t1};
			dp1_t2  <= {34'b0, dd_t1[67:34]} * {34'b0, d_t1};
			ap_t2   <= ap_t1;
			nx_t2   <= nx_t1;
			ny_t2   <= ny_t1;

			den_t3  <= DEN_W'(dp0_t2) + (DEN_W'(dp1_t2) << 34);
			numx_t3 <= numx_t2;
			numy_t3 <= numy_t2;
			ap_t3   <= ap_t2;
			nx_t3   <= nx_t2;
			ny_t3   <= ny_t2;

			// quotient at or above 2^47 clamps
			side_t4.sat_x   <= {{(DEN_W+Q_W-NUM_W+1){1'b0}}, numx_t3}
				>= ({{(Q_W+1){1'b0}}, den_t3} << Q_W);
			side_t4.sat_y   <= {{(DEN_W+Q_W-NUM_W+1){1'b0}}, numy_t3}
				>= ({{(Q_W+1){1'b0}}, den_t3} << Q_W);
			side_t4.neg_x   <= nx_t3;
			side_t4.neg_y   <= ny_t3;
			side_t4.applied <= ap_t3;
			den_t4  <= den_t3;
			numx_t4 <= numx_t3;
			numy_t4 <= numy_t3;
		end
	end

	// divider chain, most significant quotient bit first
	logic             dv   [ND+1];
	logic [NUM_W-1:0] drx  [ND+1];
	logic [NUM_W-1:0] dry  [ND+1];
	logic [Q_W-1:0]   dqx  [ND+1];
	logic [Q_W-1:0]   dqy  [ND+1];
	logic [DEN_W-1:0] dden [ND+1];
	div_side_t        dside[ND+1];

	assign dv[0]    = v_t4;
	assign drx[0]   = numx_t4;
	assign dry[0]   = numy_t4;
	assign dqx[0]   = '0;
	assign dqy[0]   = '0;
	assign dden[0]  = den_t4;
	assign dside[0] = side_t4;

	for (genvar i = 0; i < ND; i++) begin : g_div
		gpf_div_cell #(.BIT(ND - 1 - i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (dv[i]),
			.rem_x_in (drx[i]),
			.rem_y_in (dry[i]),
			.q_x_in   (dqx[i]),
			.q_y_in   (dqy[i]),
			.den_in   (dden[i]),
			.side_in  (dside[i]),
			.valid_out(dv[i+1]),
			.rem_x_out(drx[i+1]),
			.rem_y_out(dry[i+1]),
			.q_x_out  (dqx[i+1]),
			.q_y_out  (dqy[i+1]),
			.den_out  (dden[i+1]),
			.side_out (dside[i+1])
		);
	end

	// clamp, sign and close-range masking
	div_side_t          fin;
	logic [FORCE_W-1:0] fx_mag, fy_mag, fx, fy;

	assign fin    = dside[ND];
	assign fx_mag = {1'b0, fin.sat_x ? FORCE_MAX : dqx[ND]};
	assign fy_mag = {1'b0, fin.sat_y ? FORCE_MAX : dqy[ND]};
	assign fx     = !fin.applied ? '0 : (fin.neg_x ? ~fx_mag + FORCE_W'(1) : fx_mag);
	assign fy     = !fin.applied ? '0 : (fin.neg_y ? ~fy_mag + FORCE_W'(1) : fy_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.force_x <= fx;
			out_data_q.force_y <= fy;
			out_data_q.applied <= fin.applied;
		end
	end

	`GPF_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v_s1)
	`GPF_ASSERT_NOW(a_close_is_zero, out_valid && !out_data.applied,
		out_data.force_x == '0 && out_data.force_y == '0)
	`GPF_ASSERT_NOW(a_symmetric_sat, out_valid,
		out_data.force_x != {1'b1, {(FORCE_W-1){1'b0}}}
		&& out_data.force_y != {1'b1, {(FORCE_W-1){1'b0}}})

endmodule
